### hdl/tcw_pkg.sv
// Shared constants for the text console writer: default geometry, operation
// codes, configuration register indexes, character codes and register resets.
// No dependencies.
package tcw_pkg;

  // Default screen geometry
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  // Operation codes carried in the input tuser
  localparam logic [1:0] FUNC_PUT       = 2'd0;
  localparam logic [1:0] FUNC_FILL_SCR  = 2'd1;
  localparam logic [1:0] FUNC_FILL_RECT = 2'd2;
  localparam logic [1:0] FUNC_READ      = 2'd3;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TEXT_COLOR    = 2'd0;
  localparam logic [1:0] REG_BACK_COLOR    = 2'd1;
  localparam logic [1:0] REG_CURSOR_FOLLOW = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Register reset values
  localparam logic [3:0] RST_TEXT_COLOR    = 4'hF;
  localparam logic [3:0] RST_BACK_COLOR    = 4'h0;
  localparam logic       RST_CURSOR_FOLLOW = 1'b1;

endpackage

### hdl/text_console_writer_unit.sv
// Text console writer: cursor, put/fill/read sequencer and the cell store.
// Cell store is a single-port-write, registered-read memory inside this file.
// Depends on tcw_pkg.
//
// Sequence: a put is accepted, written, then its result staged; a read is accepted,
//   its cell read, then its result staged; a rectangle fill is set up, then walked,
//   and a screen fill walks the store; a put that scrolls copies one cell per cycle,
//   then clears the last row. Throughput: one item at a time; the next word is taken
//   the cycle after the result is registered, which waits for a free output register.
//   Fills and scrolls hold off input for their whole walk of the store.
// Reset: asynchronous, active low. After reset the store is swept to zero,
//   one cell per cycle; input is held off meanwhile.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: char_code[7:0], rect_col[14:8], rect_row[19:15], rect_width[26:20],
  //        rect_height[31:27], fill_color[35:32], read_addr[46:36], zero[47]
  input  logic [47:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cursor_pos[10:0], cell_data[26:11], zero[31:27]
  output logic [31:0] m_axis_tdata,
  // tuser: cursor_update[0]
  output logic        m_axis_tuser,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);         // cell address
  localparam int unsigned CIW   = $clog2(COLUMNS);       // column index
  localparam int unsigned RIW   = $clog2(ROWS);          // row index
  localparam int unsigned CW    = $clog2(COLUMNS + 1);   // column bound
  localparam int unsigned RW    = $clog2(ROWS + 1);      // row bound
  localparam int unsigned XW    = (CW > 8) ? CW : 8;     // rect column sum
  localparam int unsigned YW    = (RW > 6) ? RW : 6;     // rect row sum
  localparam int unsigned PW    = (AW > 11) ? AW : 11;   // reported index

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_PUT    = 9'b000000100,
    ST_SCROLL = 9'b000001000,
    ST_SDRAIN = 9'b000010000,
    ST_FSETUP = 9'b000100000,
    ST_FILL   = 9'b001000000,
    ST_READ   = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0] text_q, back_q;
  logic       follow_q;

  // cursor: column, row and the row's base address
  logic [CIW-1:0] col_q;
  logic [RIW-1:0] row_q;
  logic [AW-1:0]  base_q;

  // sweep counter: clear pass address, scroll source
  logic [AW-1:0] s_q;
  logic          cp_v_q;
  logic [AW-1:0] cp_dst_q;

  // fill walker
  logic [CIW-1:0] f_c0_q, f_col_q;
  logic [CW-1:0]  f_c1_q;
  logic [RW-1:0]  f_row_q, f_r1_q;
  logic [AW-1:0]  f_base_q;
  logic [3:0]     f_color_q;

  // latched item payload
  logic [7:0] char_q;
  logic [6:0] rc_q, rw_q;
  logic [4:0] rr_q, rh_q;
  logic       rd_ok_q;

  // result staging and output register
  logic        res_upd_q;
  logic [15:0] res_data_q;
  logic        m_valid_q, m_upd_q;
  logic [10:0] m_pos_q;
  logic [15:0] m_data_q;

  // cell store
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  // unpacked input fields
  logic [1:0]  in_func;
  logic [7:0]  in_char;
  logic [6:0]  in_rc, in_rw;
  logic [4:0]  in_rr, in_rh;
  logic [3:0]  in_color;
  logic [10:0] in_raddr;

  assign in_func  = s_axis_tuser;
  assign in_char  = s_axis_tdata[7:0];
  assign in_rc    = s_axis_tdata[14:8];
  assign in_rr    = s_axis_tdata[19:15];
  assign in_rw    = s_axis_tdata[26:20];
  assign in_rh    = s_axis_tdata[31:27];
  assign in_color = s_axis_tdata[35:32];
  assign in_raddr = s_axis_tdata[46:36];

  logic accept, cfg_wr, out_free, is_nl, col_last, row_last, wrap;
  logic fill_col_end, fill_row_end;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign is_nl    = (char_q == CHAR_NEWLINE);
  assign col_last = (col_q == CIW'(COLUMNS - 1));
  assign row_last = (row_q == RIW'(ROWS - 1));
  assign wrap     = is_nl || col_last;

  assign fill_col_end = ((CW'(f_col_q) + CW'(1)) == f_c1_q);
  assign fill_row_end = ((f_row_q + RW'(1)) == f_r1_q);

  // rectangle clipping against the screen edges
  logic [XW-1:0] rx0, rx1;
  logic [YW-1:0] ry0, ry1;
  logic          rect_empty;
  logic [CW-1:0] clip_c1;
  logic [RW-1:0] clip_r1;

  always_comb begin
    rx0 = XW'(rc_q);
    rx1 = XW'(rc_q) + XW'(rw_q);
    ry0 = YW'(rr_q);
    ry1 = YW'(rr_q) + YW'(rh_q);
    rect_empty = (rx0 >= XW'(COLUMNS)) || (ry0 >= YW'(ROWS)) ||
                 (rw_q == 7'd0) || (rh_q == 5'd0);
    clip_c1 = (rx1 > XW'(COLUMNS)) ? CW'(COLUMNS) : CW'(rx1);
    clip_r1 = (ry1 > YW'(ROWS)) ? RW'(ROWS) : RW'(ry1);
  end

  // read address out of range returns zero
  logic [PW-1:0] raddr_w, cpos_w;
  assign raddr_w = PW'(in_raddr);
  assign cpos_w  = PW'(base_q) + PW'(col_q);

  assign s_axis_tready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (s_q == AW'(CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_PUT:       state_d = ST_PUT;
            FUNC_FILL_SCR:  state_d = ST_FILL;
            FUNC_FILL_RECT: state_d = ST_FSETUP;
            default:        state_d = ST_READ;
          endcase
        end
      end
      ST_PUT:    state_d = (wrap && row_last) ? ST_SCROLL : ST_RESULT;
      ST_SCROLL: if (s_q == AW'(CELLS - 1)) state_d = ST_SDRAIN;
      ST_SDRAIN: state_d = ST_FILL;
      ST_FSETUP: state_d = rect_empty ? ST_RESULT : ST_FILL;
      ST_FILL:   if (fill_col_end && fill_row_end) state_d = ST_RESULT;
      ST_READ:   state_d = ST_RESULT;
      ST_RESULT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // write port: clear sweep, pending scroll copy, fill, then put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base_q + AW'(col_q);
    mem_wdata = {back_q, text_q, char_q};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = s_q;
      mem_wdata = '0;
    end else if (cp_v_q) begin
      mem_we    = 1'b1;
      mem_waddr = cp_dst_q;
      mem_wdata = rdata_q;
    end else if (state_q == ST_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = f_base_q + AW'(f_col_q);
      mem_wdata = {f_color_q, f_color_q, CHAR_SPACE};
    end else if (state_q == ST_PUT && !is_nl) begin
      mem_we    = 1'b1;
    end
  end

  // read port: scroll source while scrolling, else the requested cell
  assign mem_raddr = (state_q == ST_SCROLL) ? s_q : AW'(in_raddr);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // control, cursor and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      text_q    <= RST_TEXT_COLOR;
      back_q    <= RST_BACK_COLOR;
      follow_q  <= RST_CURSOR_FOLLOW;
      col_q     <= '0;
      row_q     <= '0;
      base_q    <= '0;
      s_q       <= '0;
      cp_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cp_v_q  <= (state_q == ST_SCROLL);

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_TEXT_COLOR:    text_q   <= pwdata[3:0];
          REG_BACK_COLOR:    back_q   <= pwdata[3:0];
          REG_CURSOR_FOLLOW: follow_q <= pwdata[0];
          default: ;
        endcase
      end

      case (state_q)
        // advance the clear pointer, then park it at the scroll start
        ST_CLEAR:  s_q <= (s_q == AW'(CELLS - 1)) ? AW'(COLUMNS) : s_q + AW'(1);
        ST_PUT: begin
          if (wrap) begin
            col_q <= '0;
            if (!row_last) begin
              row_q  <= row_q + RIW'(1);
              base_q <= base_q + AW'(COLUMNS);
            end
          end else begin
            col_q <= col_q + CIW'(1);
          end
          s_q <= AW'(COLUMNS);
        end
        ST_SCROLL: s_q <= s_q + AW'(1);
        default: ;
      endcase

      // load a new word, else drop the one taken by the receiver
      if (state_q == ST_RESULT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload: item fields, fill walker, scroll pipe, results
  always_ff @(posedge clk_i) begin
    cp_dst_q <= s_q - AW'(COLUMNS);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          char_q     <= in_char;
          rc_q       <= in_rc;
          rr_q       <= in_rr;
          rw_q       <= in_rw;
          rh_q       <= in_rh;
          rd_ok_q    <= (raddr_w < PW'(CELLS));
          res_upd_q  <= 1'b0;
          res_data_q <= '0;
          f_color_q  <= in_color;
          f_c0_q     <= '0;
          f_col_q    <= '0;
          f_c1_q     <= CW'(COLUMNS);
          f_row_q    <= '0;
          f_r1_q     <= RW'(ROWS);
          f_base_q   <= '0;
        end
      end
      ST_PUT:    res_upd_q <= !is_nl && follow_q;
      ST_SDRAIN: begin
        // clear the bottom row in the back color
        f_color_q <= back_q;
        f_c0_q    <= '0;
        f_col_q   <= '0;
        f_c1_q    <= CW'(COLUMNS);
        f_row_q   <= RW'(ROWS - 1);
        f_r1_q    <= RW'(ROWS);
        f_base_q  <= AW'((ROWS - 1) * COLUMNS);
      end
      ST_FSETUP: begin
        f_c0_q   <= CIW'(rc_q);
        f_col_q  <= CIW'(rc_q);
        f_c1_q   <= clip_c1;
        f_row_q  <= RW'(rr_q);
        f_r1_q   <= clip_r1;
        f_base_q <= AW'(rr_q) * AW'(COLUMNS);
      end
      ST_FILL: begin
        if (fill_col_end) begin
          f_col_q  <= f_c0_q;
          f_row_q  <= f_row_q + RW'(1);
          f_base_q <= f_base_q + AW'(COLUMNS);
        end else begin
          f_col_q <= f_col_q + CIW'(1);
        end
      end
      ST_READ:   res_data_q <= rd_ok_q ? rdata_q : '0;
      ST_RESULT: begin
        if (out_free) begin
          m_pos_q  <= cpos_w[10:0];
          m_upd_q  <= res_upd_q;
          m_data_q <= res_data_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q, m_pos_q};
  assign m_axis_tuser  = m_upd_q;

  // configuration read back
  always_comb begin
    case (paddr[3:2])
      REG_TEXT_COLOR:    prdata = {28'd0, text_q};
      REG_BACK_COLOR:    prdata = {28'd0, back_q};
      REG_CURSOR_FOLLOW: prdata = {31'd0, follow_q};
      default:           prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // a scroll copy write always comes in the cycle after its scroll read
  a_copy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_v_q |-> $past(state_q == ST_SCROLL))
    else $error("scroll copy write without matching read");

  // the store is never written while waiting for an item
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("cell store written while idle");

  // cursor stays on the screen and its base tracks the row
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS) &&
    (32'(base_q) == 32'(row_q) * COLUMNS))
    else $error("cursor out of range or base mismatch");

  // a read result is only taken right after the read was issued
  a_read_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(state_q == ST_IDLE))
    else $error("read data taken without a read issue cycle");

endmodule

### bench/text_console_writer_unit_tb.sv
// Self-checking bench for text_console_writer_unit: streams put, fill and read
// commands, predicts every reply from a shadow screen and compares each word.
// Depends on tcw_pkg and the text_console_writer_unit RTL.
module text_console_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int SCR_COLS  = DEF_COLUMNS;
  localparam int SCR_ROWS  = DEF_ROWS;
  localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

  // Register index with no register behind it; writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam int     RESET_CYCLES   = 11;
  localparam int     PHASES         = 6;
  localparam int     CMDS_PER_PHASE = 113;
  localparam int     BACKLOG_DEPTH  = 8;
  localparam int     IDLE_PCT       = 18;
  localparam int     HOLD_AT_WORD   = 420;
  localparam int     HOLD_CYCLES    = 1500;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     PRINT_LIMIT    = 50;
  // The reset sweep, a handful of whole-screen fills and scrolls, and random
  // stalls stay far below this
  localparam longint CYCLE_LIMIT    = 1_000_000;

  // One command word; fields listed top down, so char_code lands in bit 0
  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] read_addr;
    logic [3:0]  fill_color;
    logic [4:0]  rect_height;
    logic [6:0]  rect_width;
    logic [4:0]  rect_row;
    logic [6:0]  rect_col;
    logic [7:0]  char_code;
  } console_cmd_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic        cursor_update;
    logic [10:0] cursor_pos;
  } console_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // char_code, rect_col, rect_row, rect_width,
                                     // rect_height, fill_color, read_addr, zero
  logic [1:0]  s_axis_tuser  = '0;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // cursor_pos, cell_data, zero
  logic        m_axis_tuser;         // cursor_update
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the console: cell store, cursor and the three registers
  logic [15:0]  screen_shadow [SCR_CELLS];
  int unsigned  cur_col = 0;
  int unsigned  cur_row = 0;
  logic [3:0]   text_color_q = RST_TEXT_COLOR;
  logic [3:0]   back_color_q = RST_BACK_COLOR;
  logic         follow_q     = RST_CURSOR_FOLLOW;

  console_cmd_t   cmd_backlog [$];     // commands waiting for the driver
  console_reply_t awaited_replies [$]; // predicted replies, oldest first
  console_cmd_t   offered_cmd;

  int     words_accepted = 0;
  int     replies_seen   = 0;
  int     mismatch_count = 0;
  int     hold_left      = 0;
  logic   hold_done      = 1'b0;
  logic   calm           = 1'b0;     // no idling on either side while set
  longint cycle_count    = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t ns: reply %0d: %s is %0d, expected %0d",
               $time, replies_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  // Paint spaces in one color over a rectangle, clipped at the right and bottom
  task automatic paint_area(input int unsigned c0, r0, w, h, input logic [3:0] color);
    int unsigned c1, r1;
    if (c0 >= SCR_COLS || r0 >= SCR_ROWS) return;
    c1 = (c0 + w > SCR_COLS) ? SCR_COLS : c0 + w;
    r1 = (r0 + h > SCR_ROWS) ? SCR_ROWS : r0 + h;
    for (int unsigned r = r0; r < r1; r++)
      for (int unsigned c = c0; c < c1; c++)
        screen_shadow[r * SCR_COLS + c] = {color, color, CHAR_SPACE};
  endtask

  // Move to column 0 of the next row; at the bottom shift every row up and
  // clear the last one in the back color
  task automatic advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCR_ROWS) begin
      for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
        screen_shadow[i] = screen_shadow[i + SCR_COLS];
      paint_area(0, SCR_ROWS - 1, SCR_COLS, 1, back_color_q);
      cur_row = SCR_ROWS - 1;
    end
  endtask

  task automatic apply_console_cmd(input console_cmd_t cmd, output console_reply_t reply);
    reply = '0;
    case (cmd.func)
      FUNC_PUT: begin
        if (cmd.char_code == CHAR_NEWLINE) begin
          advance_row();
        end else begin
          screen_shadow[cur_row * SCR_COLS + cur_col] =
            {back_color_q, text_color_q, cmd.char_code};
          cur_col++;
          if (cur_col >= SCR_COLS) advance_row();
          reply.cursor_update = follow_q;
        end
      end
      FUNC_FILL_SCR: begin
        paint_area(0, 0, SCR_COLS, SCR_ROWS, cmd.fill_color);
      end
      FUNC_FILL_RECT: begin
        paint_area(32'(cmd.rect_col), 32'(cmd.rect_row), 32'(cmd.rect_width),
                   32'(cmd.rect_height), cmd.fill_color);
      end
      FUNC_READ: begin
        if (cmd.read_addr < SCR_CELLS) reply.cell_data = screen_shadow[cmd.read_addr];
      end
      default: ;
    endcase
    reply.cursor_pos = 11'(cur_row * SCR_COLS + cur_col);
  endtask

  task automatic set_console_reg(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      REG_TEXT_COLOR:    text_color_q = value[3:0];
      REG_BACK_COLOR:    back_color_q = value[3:0];
      REG_CURSOR_FOLLOW: follow_q     = value[0];
      default: ;
    endcase
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready
  task automatic write_console_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_console_reg(idx, value);
  endtask

  task automatic push_cmd(input logic [1:0] func, input logic [7:0] ch,
                          input logic [6:0] c, input logic [4:0] r,
                          input logic [6:0] w, input logic [4:0] h,
                          input logic [3:0] color, input logic [10:0] addr);
    console_cmd_t cmd;
    cmd = '{func: func, read_addr: addr, fill_color: color, rect_height: h,
            rect_width: w, rect_row: r, rect_col: c, char_code: ch};
    cmd_backlog.push_back(cmd);
  endtask

  // Random command: every field starts fully random, then the fields that the
  // chosen operation uses get shaped
  task automatic push_random_cmd(input int unsigned nl_pct);
    console_cmd_t cmd;
    logic [63:0]  bits;
    int unsigned  pick;
    int unsigned  base;
    bits = {$urandom, $urandom};
    cmd  = bits[48:0];
    pick = $urandom_range(0, 999);
    if (pick < 7) begin
      cmd.func = FUNC_FILL_SCR;
    end else if (pick < 620) begin
      cmd.func = FUNC_PUT;
      if ($urandom_range(0, 99) < nl_pct) cmd.char_code = CHAR_NEWLINE;
    end else if (pick < 750) begin
      cmd.func = FUNC_FILL_RECT;
      // Mostly on screen; otherwise keep the raw origin, past the edges too
      if ($urandom_range(0, 6) != 0) begin
        cmd.rect_col = 7'($urandom_range(0, SCR_COLS - 1));
        cmd.rect_row = 5'($urandom_range(0, SCR_ROWS - 1));
      end
      // Keep big areas rare: each one walks up to the whole store
      case ($urandom_range(0, 19))
        0: ;
        1, 2, 3, 4: cmd.rect_height = 5'($urandom_range(0, 1));
        5, 6, 7:    cmd.rect_width  = 7'($urandom_range(0, 1));
        default: begin
          cmd.rect_width  = 7'($urandom_range(0, 8));
          cmd.rect_height = 5'($urandom_range(0, 4));
        end
      endcase
    end else begin
      cmd.func = FUNC_READ;
      pick = $urandom_range(0, 99);
      base = cur_row * SCR_COLS + cur_col;
      // Aim 45 percent of reads just behind the cursor, where fresh text sits
      if (pick < 45) begin
        cmd.read_addr = 11'(base > 160 ? base - $urandom_range(0, 160)
                                       : $urandom_range(0, base));
      end else if (pick < 85) begin
        cmd.read_addr = 11'($urandom_range(0, SCR_CELLS - 1));
      end
    end
    cmd_backlog.push_back(cmd);
  endtask

  // Hold until every command is in and every reply is out, then settle;
  // look at the falling edge, once the rising-edge updates have landed
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Command driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk_i) begin : drive_cmds
    console_reply_t reply;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_console_cmd(offered_cmd, reply);
        awaited_replies.push_back(reply);
        words_accepted <= words_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered_cmd = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, offered_cmd.read_addr, offered_cmd.fill_color,
                            offered_cmd.rect_height, offered_cmd.rect_width,
                            offered_cmd.rect_row, offered_cmd.rect_col,
                            offered_cmd.char_code};
          s_axis_tuser  <= offered_cmd.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply side ready: random stalls, plus one long hold-off that lets the
  // block back up and push back on the command stream
  always @(posedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Reply monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : check_replies
    console_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply word with none awaited, tdata", m_axis_tdata, 0);
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tdata[10:0] !== want.cursor_pos)
          report_mismatch("cursor_pos", 32'(m_axis_tdata[10:0]), 32'(want.cursor_pos));
        if (m_axis_tuser !== want.cursor_update)
          report_mismatch("cursor_update", 32'(m_axis_tuser), 32'(want.cursor_update));
        if (m_axis_tdata[26:11] !== want.cell_data)
          report_mismatch("cell_data", 32'(m_axis_tdata[26:11]), 32'(want.cell_data));
      end
      replies_seen++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    // Newline share of puts per phase: low rates let lines run to the wrap,
    // high rates drive the cursor to the bottom and keep scrolling
    int unsigned nl_pct [PHASES];
    nl_pct = '{2, 15, 5, 25, 2, 10};
    for (int i = 0; i < SCR_CELLS; i++) screen_shadow[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared store, character extremes, newline, clipped and
    // empty rectangles, out-of-range read, both fill color extremes
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       8'h41, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       8'hFF, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       CHAR_NEWLINE, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       8'h80, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd2);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd80);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd2047);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd1999);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd0, 5'd0, 7'd3, 5'd2, 4'hA, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd81);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd78, 5'd23, 7'd127, 5'd31, 4'h5, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd1999);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd80, 5'd0, 7'd5, 5'd5, 4'h3, 11'd0);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd127, 5'd31, 7'd127, 5'd31, 4'h6, 11'd0);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd10, 5'd10, 7'd0, 5'd5, 4'h7, 11'd0);
    push_cmd(FUNC_FILL_RECT, 8'h00, 7'd10, 5'd10, 7'd5, 5'd0, 4'h7, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd810);
    push_cmd(FUNC_FILL_SCR,  8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'hF, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd1000);
    push_cmd(FUNC_FILL_SCR,  8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_PUT,       CHAR_NEWLINE, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd0);
    push_cmd(FUNC_READ,      8'h00, 7'd0, 5'd0, 7'd0, 5'd0, 4'h0, 11'd1999);

    for (int p = 0; p < PHASES; p++) begin
      // Reprogram only once the block has drained
      wait_idle();
      case (p)
        0: begin
          write_console_reg(REG_TEXT_COLOR,    32'h0);
          write_console_reg(REG_BACK_COLOR,    32'hF);
          write_console_reg(REG_CURSOR_FOLLOW, 32'h0);
        end
        1: begin
          // Upper bits must be dropped; the unmapped index must change nothing
          write_console_reg(REG_TEXT_COLOR,    32'hFFFF_FFFF);
          write_console_reg(REG_BACK_COLOR,    32'h8000_0000);
          write_console_reg(REG_CURSOR_FOLLOW, 32'h0000_0003);
          write_console_reg(REG_UNMAPPED,      $urandom);
        end
        default: begin
          write_console_reg(REG_TEXT_COLOR,    $urandom);
          write_console_reg(REG_BACK_COLOR,    $urandom);
          write_console_reg(REG_CURSOR_FOLLOW, $urandom);
        end
      endcase
      calm <= (p == 2);
      for (int n = 0; n < CMDS_PER_PHASE; n++) begin
        // Keep the backlog short so read targets track the cursor closely
        while (cmd_backlog.size() >= BACKLOG_DEPTH) @(posedge clk_i);
        push_random_cmd(nl_pct[p]);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
